[rtl/core/psq_pkg.sv]
// Package for the pending signal queue.
// Request/result payload types, controller state, command and status structs.
`timescale 1ns / 1ps

package psq_pkg;

    localparam int SLOT_INDEX_BITS_DEF = 4;
    localparam logic [7:0] BASE_RESET = 8'd33;

    localparam logic MODE_POST  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] signal_set;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [7:0] signal_number;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POST_READ,
        ST_POST_EVAL,
        ST_FETCH_START,
        ST_FETCH_READ,
        ST_FETCH_EVAL
    } state_t;

    typedef struct packed {
        logic load;
        logic post_eval;
        logic fetch_rel;
        logic fetch_eval;
    } cmd_t;

    typedef struct packed {
        logic rel_nonzero;
        logic post_last;
        logic post_full;
        logic slot_empty;
        logic at_tail;
    } stat_t;

endpackage

[rtl/core/psq_datapath.sv]
// Datapath of the pending signal queue: slot memory, masks, ring indices, result.
// Depends on psq_pkg; driven by psq_ctrl through cmd_t / stat_t.
`timescale 1ns / 1ps

module psq_datapath
    import psq_pkg::*;
#(
    parameter int SLOT_INDEX_BITS = SLOT_INDEX_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       request,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  cmd_t       cmd,
    output stat_t      stat,
    output logic       done,
    output res_t       result
);

    localparam int SLOT_COUNT = 1 << SLOT_INDEX_BITS;

    function automatic logic [4:0] lowest_bit(input logic [31:0] x);
        logic [4:0] idx;
        idx = 5'd31;
        for (int i = 31; i >= 0; i--)
        begin
            if (x[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    logic [31:0]                slot_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]      valid_reg, valid_next;
    logic [31:0]                rdata_reg;
    logic                       rvalid_reg;
    logic [7:0]                 base_reg;
    logic [31:0]                rel_reg, rel_next;
    logic [31:0]                rel_in_reg;
    logic [31:0]                rt_reg, rt_next;
    logic [SLOT_INDEX_BITS-1:0] head_reg, head_next;
    logic [SLOT_INDEX_BITS-1:0] tail_reg, tail_next;
    logic [SLOT_INDEX_BITS-1:0] ptr_reg, ptr_next;
    logic                       done_reg, done_next;
    res_t                       res_reg, res_next;

    logic [31:0]                old_mask;
    logic [31:0]                keep_mask;
    logic [SLOT_INDEX_BITS-1:0] ptr_inc;
    logic [4:0]                 rel_bit;
    logic [4:0]                 slot_bit;
    logic                       mem_we;
    logic [31:0]                mem_wdata;

    assign old_mask  = rvalid_reg ? rdata_reg : 32'd0;
    assign keep_mask = rt_reg & old_mask;
    assign ptr_inc   = ptr_reg + SLOT_INDEX_BITS'(1);
    assign rel_bit   = lowest_bit(rel_reg);
    assign slot_bit  = lowest_bit(old_mask);

    assign stat.rel_nonzero = |rel_reg;
    assign stat.post_last   = (keep_mask == 32'd0);
    assign stat.post_full   = (ptr_inc == head_reg);
    assign stat.slot_empty  = (old_mask == 32'd0);
    assign stat.at_tail     = (ptr_reg == tail_reg);

    always_comb
    begin
        rel_next   = rel_reg;
        rt_next    = rt_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        ptr_next   = ptr_reg;
        valid_next = valid_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_wdata  = old_mask | rt_reg;

        if (cmd.load)
        begin
            rt_next  = request.signal_set[63:32];
            ptr_next = (request.mode == MODE_FETCH) ? head_reg : tail_reg;
        end

        if (cmd.post_eval)
        begin
            mem_we             = 1'b1;
            mem_wdata          = old_mask | rt_reg;
            valid_next[ptr_reg] = 1'b1;
            rt_next            = keep_mask;
            if (stat.post_last)
            begin
                rel_next  = rel_reg | rel_in_reg;
                tail_next = ptr_reg;
                done_next = 1'b1;
                res_next  = '{status: STATUS_OK, signal_number: 8'd0};
            end
            else if (stat.post_full)
            begin
                done_next = 1'b1;
                res_next  = '{status: STATUS_FULL, signal_number: 8'd0};
            end
            else
            begin
                ptr_next = ptr_inc;
            end
        end

        if (cmd.fetch_rel)
        begin
            rel_next  = rel_reg & ~(32'd1 << rel_bit);
            done_next = 1'b1;
            res_next  = '{status: STATUS_OK, signal_number: {3'd0, rel_bit} + 8'd1};
        end

        if (cmd.fetch_eval)
        begin
            if (!stat.slot_empty)
            begin
                mem_we              = 1'b1;
                mem_wdata           = old_mask & ~(32'd1 << slot_bit);
                valid_next[ptr_reg] = 1'b1;
                head_next           = ptr_reg;
                done_next           = 1'b1;
                res_next = '{status: STATUS_OK, signal_number: base_reg + {3'd0, slot_bit}};
            end
            else if (stat.at_tail)
            begin
                done_next = 1'b1;
                res_next  = '{status: STATUS_OK, signal_number: 8'd0};
            end
            else
            begin
                ptr_next = ptr_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[ptr_reg] <= mem_wdata;
        end
        rdata_reg <= slot_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rel_in_reg <= request.signal_set[31:0];
        end
        rt_reg  <= rt_next;
        ptr_reg <= ptr_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            base_reg   <= BASE_RESET;
            rel_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rvalid_reg <= valid_reg[ptr_reg];
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            rel_reg  <= rel_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/core/psq_ctrl.sv]
// Controller of the pending signal queue: sequences post and fetch requests.
// Depends on psq_pkg; commands psq_datapath via cmd_t, reads stat_t.
`timescale 1ns / 1ps

module psq_ctrl
    import psq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  mode,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (mode == MODE_FETCH) ? ST_FETCH_START : ST_POST_READ;
                end
            end
            ST_POST_READ:
            begin
                state_next = ST_POST_EVAL;
            end
            ST_POST_EVAL:
            begin
                state_next = (stat.post_last || stat.post_full) ? ST_IDLE : ST_POST_READ;
            end
            ST_FETCH_START:
            begin
                state_next = stat.rel_nonzero ? ST_IDLE : ST_FETCH_READ;
            end
            ST_FETCH_READ:
            begin
                state_next = ST_FETCH_EVAL;
            end
            ST_FETCH_EVAL:
            begin
                state_next = (!stat.slot_empty || stat.at_tail) ? ST_IDLE : ST_FETCH_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_POST_EVAL:
            begin
                cmd.post_eval = 1'b1;
            end
            ST_FETCH_START:
            begin
                cmd.fetch_rel = stat.rel_nonzero;
            end
            ST_FETCH_EVAL:
            begin
                cmd.fetch_eval = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/pending_signal_queue.sv]
// Top level of the pending signal queue.
// Depends on psq_pkg; instantiates psq_ctrl and psq_datapath.
//
// Usage:
//   Request channel: a request (mode, signal_set) is taken at a clock edge
//   with start high and busy low. mode MODE_POST posts signal_set, mode
//   MODE_FETCH fetches the next pending signal.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall it. One result per request.
//   Config channel: cfg_data (realtime_base) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
// Slot walk: a post visits ring slots from the tail, a realtime fetch from
//   the head, both at least one; a reliable fetch visits none.
//   Each slot visit is a registered read and an evaluate cycle on the
//   single-port slot memory; busy is high for the whole walk.
//   A new request may be accepted in the cycle done is high.
// Reset: the reliable mask, valid bits and indices clear at once, realtime_base = 33;
//   no clearing pass, the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module pending_signal_queue
    import psq_pkg::*;
#(
    parameter int SLOT_INDEX_BITS = SLOT_INDEX_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       request,
    output logic       done,
    output res_t       result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    psq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (request.mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    psq_datapath #(
        .SLOT_INDEX_BITS (SLOT_INDEX_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule

[rtl/core/psq_checker.sv]
// Port-level checker for the pending signal queue, bound to the top level.
// Depends on psq_pkg and the ports of pending_signal_queue.
`timescale 1ns / 1ps

module psq_checker
    import psq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on back-to-back cycles");

    a_full_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_FULL) |-> (result.signal_number == 8'd0))
        else $error("full status with nonzero signal number");

endmodule

bind pending_signal_queue psq_checker u_psq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
